### rtl/hti_pkg.sv
// ----------------------------------------------------------------------------
// hti_pkg
// Shared types and codes for the bounded chained hash table core.
// ----------------------------------------------------------------------------
package hti_pkg;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_REPLACED  = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef struct packed {
    logic        action;
    logic [31:0] key;
    logic [63:0] value;
  } in_word_t;

  typedef struct packed {
    status_t status;
    logic    table_empty;
  } out_word_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_READ,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic modulo;
    logic read;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_busy;
  } sts_t;

endpackage

### rtl/hti_ram.sv
// ----------------------------------------------------------------------------
// hti_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/hti_ctrl.sv
// ----------------------------------------------------------------------------
// hti_ctrl
// Sequencer: clearing pass, accept, bucket select, row read, update.
// ----------------------------------------------------------------------------
module hti_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  hti_pkg::sts_t sts,
  output hti_pkg::cmd_t cmd
);

  import hti_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:  if (sts.clear_done) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_MOD;
      S_MOD:    state_nxt = S_READ;
      S_READ:   state_nxt = S_UPDATE;
      S_UPDATE: if (!sts.out_busy) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_CLEAR:  cmd.clear = 1'b1;
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_MOD:    cmd.modulo = 1'b1;
      S_READ:   cmd.read = 1'b1;
      S_UPDATE: cmd.update = !sts.out_busy;
      default:  cmd = '0;
    endcase
  end

endmodule

### rtl/hti_dpath.sv
// ----------------------------------------------------------------------------
// hti_dpath
// Bucket index, row store, parallel slot compare, item count, result register.
// ----------------------------------------------------------------------------
module hti_dpath #(
  parameter int BUCKETS    = 10,
  parameter int WAYS       = 4,
  parameter int VALUE_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hti_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hti_pkg::out_word_t out_data,
  input  hti_pkg::cmd_t      cmd,
  output hti_pkg::sts_t      sts
);

  import hti_pkg::*;

  localparam int SLOTS = BUCKETS * WAYS;
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SH    = 32 + $clog2(BUCKETS);
  localparam logic [32:0] RECIP = 33'((65'(1) << SH) / BUCKETS);
  localparam int RMW   = $clog2(2 * BUCKETS) + 1;
  localparam int EW    = 1 + 32 + VALUE_BITS;
  localparam int RW    = WAYS * EW;

  logic                  act_r;
  logic [31:0]           key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [31:0]           quot_r;
  logic [BW-1:0]         bucket_r;
  logic [BW-1:0]         clr_cnt_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic                  out_valid_r;
  out_word_t             out_data_r;
  out_word_t             out_data_nxt;

  logic [64:0]    prod;
  logic [64:0]    prod_sh;
  logic [42:0]    diff;
  logic [RMW-1:0] rem_est;
  logic [RMW-1:0] rem;

  logic [RW-1:0] row_rd;
  logic [RW-1:0] row_new;
  logic          do_write;
  logic          found;
  logic          have_free;
  logic          ram_we;
  logic [BW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;

  // reciprocal quotient estimate, at most one low
  assign prod    = 65'(in_data.key) * 65'(RECIP);
  assign prod_sh = prod >> SH;

  assign diff    = 43'(key_r) - (43'(quot_r) * 43'(BUCKETS));
  assign rem_est = diff[RMW-1:0];
  assign rem     = (rem_est >= RMW'(BUCKETS)) ? rem_est - RMW'(BUCKETS) : rem_est;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r  <= in_data.action;
      key_r  <= in_data.key;
      val_r  <= in_data.value[VALUE_BITS-1:0];
      quot_r <= prod_sh[31:0];
    end
    if (cmd.modulo) begin
      bucket_r <= BW'(rem);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear && !sts.clear_done) begin
      clr_cnt_r <= clr_cnt_r + BW'(1);
    end
  end

  assign sts.clear_done = (clr_cnt_r == BW'(BUCKETS - 1));
  assign sts.out_busy   = out_valid_r && out_stall;

  // slot compare and row rewrite
  always_comb begin
    logic          live;
    logic [31:0]   skey;
    logic [WAYS-1:0] hit_oh;
    logic [WAYS-1:0] free_oh;
    found        = 1'b0;
    have_free    = 1'b0;
    hit_oh       = '0;
    free_oh      = '0;
    row_new      = row_rd;
    do_write     = 1'b0;
    count_nxt    = count_r;
    out_data_nxt = out_data_r;
    for (int w = 0; w < WAYS; w++) begin
      live = row_rd[w*EW + EW - 1];
      skey = row_rd[w*EW + VALUE_BITS +: 32];
      if (live) begin
        if (!found && skey == key_r) begin
          found     = 1'b1;
          hit_oh[w] = 1'b1;
        end
      end else if (!have_free) begin
        have_free  = 1'b1;
        free_oh[w] = 1'b1;
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (act_r == ACT_INSERT) begin
        if (found) begin
          if (hit_oh[w]) row_new[w*EW +: VALUE_BITS] = val_r;
        end else if (free_oh[w]) begin
          row_new[w*EW +: EW] = {1'b1, key_r, val_r};
        end
      end else if (hit_oh[w]) begin
        row_new[w*EW + EW - 1] = 1'b0;
      end
    end
    if (act_r == ACT_INSERT) begin
      if (found) begin
        do_write            = 1'b1;
        out_data_nxt.status = ST_REPLACED;
      end else if (have_free) begin
        do_write            = 1'b1;
        count_nxt           = count_r + CW'(1);
        out_data_nxt.status = ST_INSERTED;
      end else begin
        out_data_nxt.status = ST_FULL;
      end
    end else begin
      if (found) begin
        do_write            = 1'b1;
        if (count_r != '0) count_nxt = count_r - CW'(1);
        out_data_nxt.status = ST_REMOVED;
      end else begin
        out_data_nxt.status = ST_NOT_FOUND;
      end
    end
    out_data_nxt.table_empty = (count_nxt == '0);
  end

  assign ram_we    = cmd.clear || (cmd.update && do_write);
  assign ram_waddr = cmd.clear ? clr_cnt_r : bucket_r;
  assign ram_wdata = cmd.clear ? '0 : row_new;

  hti_ram #(
    .WIDTH (RW),
    .DEPTH (BUCKETS)
  ) u_rows (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (cmd.read),
    .rd_addr (bucket_r),
    .rd_data (row_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.update) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(SLOTS))
    else $error("item count above slot total");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.table_empty == (count_r == '0)))
    else $error("empty flag disagrees with item count");

  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && act_r == ACT_REMOVE && found) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("remove did not drop the item count");

endmodule

### rtl/hash_table_insert_remove_core.sv
// ----------------------------------------------------------------------------
// hash_table_insert_remove_core
// Bounded hash table, separate chaining, insert or replace and remove.
// ----------------------------------------------------------------------------
// an accepted word moves through the key, bucket and row read registers to the output register
// one word at a time, through accept, reciprocal modulo, row read and row write
// the row write waits while the previous result word sits stalled in the output register
// reset: rows swept to empty one bucket at a time, in_stall held high meanwhile
// a waiting result does not block acceptance of the next word
module hash_table_insert_remove_core #(
  parameter int BUCKETS    = 10,
  parameter int WAYS       = 4,
  parameter int VALUE_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hti_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hti_pkg::out_word_t out_data
);

  import hti_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hti_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hti_dpath #(
    .BUCKETS    (BUCKETS),
    .WAYS       (WAYS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### verif/tb_hash_table_insert_remove_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hash_table_insert_remove_core
// Self-checking bench for the chained hash table core. Request words come
// from a queue and are sent by a clocked driver. A shadow table of keys,
// live marks and item count predicts status and emptiness for each accepted
// word. A clocked monitor compares every result word in order. The run has
// four phases of differing idle and stall rates; each drains every live key.
// ----------------------------------------------------------------------------
module tb_hash_table_insert_remove_core;
  import hti_pkg::*;

  localparam int BUCKETS    = 10;
  localparam int WAYS       = 4;
  localparam int VALUE_BITS = 64;
  localparam int SLOTS      = BUCKETS * WAYS;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_word_t  in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  in_word_t    pending_words[$];
  out_word_t   expected_results[$];
  out_word_t   oldest_result;
  logic [31:0] shadow_key[SLOTS];
  logic        shadow_live[SLOTS];
  int          shadow_count;
  logic [31:0] wide_keys[8];
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          mismatch_count = 0;

  hash_table_insert_remove_core #(
    .BUCKETS    (BUCKETS),
    .WAYS       (WAYS),
    .VALUE_BITS (VALUE_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic out_word_t apply_request(in_word_t w);
    int        base;
    int        hit;
    int        free_slot;
    logic      found;
    logic      have_free;
    out_word_t r;
    base      = (w.key % BUCKETS) * WAYS;
    hit       = 0;
    free_slot = 0;
    found     = 1'b0;
    have_free = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      if (shadow_live[base + i]) begin
        if (!found && shadow_key[base + i] == w.key) begin
          found = 1'b1;
          hit   = base + i;
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_slot = base + i;
      end
    end
    if (w.action == ACT_INSERT) begin
      if (found) begin
        r.status = ST_REPLACED;
      end else if (have_free) begin
        shadow_key[free_slot]  = w.key;
        shadow_live[free_slot] = 1'b1;
        shadow_count++;
        r.status = ST_INSERTED;
      end else begin
        r.status = ST_FULL;
      end
    end else begin
      if (found) begin
        shadow_live[hit] = 1'b0;
        if (shadow_count > 0) shadow_count--;
        r.status = ST_REMOVED;
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end
    r.table_empty = (shadow_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic push_word(logic action, logic [31:0] key, logic [63:0] value);
    in_word_t w;
    w.action = action;
    w.key    = key;
    w.value  = value;
    pending_words.push_back(w);
  endtask

  function automatic logic [31:0] pick_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return 32'($urandom_range(0, 2) * 3 + 1 + 10 * $urandom_range(0, 5));
    if (sel < 85) return wide_keys[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  task automatic push_random(int count);
    for (int i = 0; i < count; i++) begin
      push_word(($urandom_range(0, 99) < 55) ? ACT_INSERT : ACT_REMOVE, pick_key(),
                {$urandom(), $urandom()});
    end
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic drain_table();
    for (int s = 0; s < SLOTS; s++) begin
      if (shadow_live[s]) push_word(ACT_REMOVE, shadow_key[s], {$urandom(), $urandom()});
    end
  endtask

  // driver: prediction is made on the accepting edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(apply_request(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result word with none expected: status %0d empty %0b",
                                    out_data.status, out_data.table_empty));
        end else begin
          oldest_result = expected_results.pop_front();
          if (out_data.status !== oldest_result.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_data.status, oldest_result.status));
          if (out_data.table_empty !== oldest_result.table_empty)
            report_mismatch($sformatf("table_empty %0b, expected %0b",
                                      out_data.table_empty, oldest_result.table_empty));
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      shadow_key[s]  = '0;
      shadow_live[s] = 1'b0;
    end
    shadow_count = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: replace, remove, absent key, full bucket, extremes
    push_word(ACT_INSERT, 32'd0, 64'd0);
    push_word(ACT_INSERT, 32'd0, {64{1'b1}});
    push_word(ACT_REMOVE, 32'd0, 64'd0);
    push_word(ACT_REMOVE, 32'd0, {64{1'b1}});
    push_word(ACT_INSERT, 32'd5, 64'h0123_4567_89ab_cdef);
    push_word(ACT_INSERT, 32'd15, 64'hfedc_ba98_7654_3210);
    push_word(ACT_INSERT, 32'hffff_ffff, {64{1'b1}});
    push_word(ACT_INSERT, 32'd25, 64'd1);
    push_word(ACT_INSERT, 32'd35, 64'd2);
    push_word(ACT_INSERT, 32'hffff_ffff, 64'd0);
    push_word(ACT_REMOVE, 32'd15, 64'd0);
    push_word(ACT_INSERT, 32'd35, 64'h8000_0000_0000_0000);
    push_word(ACT_REMOVE, 32'd45, 64'd0);
    push_word(ACT_REMOVE, 32'd7, 64'd0);
    push_word(ACT_REMOVE, 32'd5, 64'd0);
    push_word(ACT_REMOVE, 32'hffff_ffff, 64'd0);
    push_word(ACT_REMOVE, 32'd25, 64'd0);
    push_word(ACT_REMOVE, 32'd35, 64'd0);
    push_word(ACT_REMOVE, 32'd35, 64'd0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      for (int i = 0; i < 8; i++) wide_keys[i] = (i == 0) ? 32'hffff_ffff : $urandom();
      push_random(300);
      wait_idle();
      drain_table();
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", expected_results.size()));
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
